[src/rtsr_pkg.sv]
// shared types, widths and codes for the record table with sorted readout
// no dependencies; used by rtsr_ctl, rtsr_dp, the top level and the dv files
package rtsr_pkg;

  localparam int MAX_RECORDS_DEF = 32;

  localparam int ID_W     = 16;
  localparam int PRICE_W  = 20;
  localparam int RANK_W   = 8;
  localparam int STATUS_W = 3;
  localparam int KEY_W    = 2;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // sort keys; the unused code falls back to id order
  localparam logic [KEY_W-1:0] KEY_ID    = 2'd0;
  localparam logic [KEY_W-1:0] KEY_PRICE = 2'd1;
  localparam logic [KEY_W-1:0] KEY_RANK  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED  = 3'd0,
    ST_DUP    = 3'd1,
    ST_FULL   = 3'd2,
    ST_RECORD = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [RANK_W-1:0]  rank;
  } rec_t;

  // controller to datapath
  typedef struct packed {
    logic    load_in;      // latch the accepted item
    logic    st_rd;        // read table at j
    logic    st_wr;        // append latched record, bump count
    logic    j_clr;
    logic    j_from_i;     // j = i + 1
    logic    j_inc;
    logic    i_clr;
    logic    i_inc;
    logic    wk_wr_copy;   // work[j] = table read data
    logic    wk_wr_head;   // work[m] = head
    logic    wk_wr_min;    // work[i] = min
    logic    wk_rd_i;
    logic    wk_rd_j;
    logic    head_ld;      // head = min = work read data, m = i
    logic    min_upd;      // keep better of min and work read data
    logic    out_load;
    logic    out_rec;      // result carries a record
    status_e out_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cmd_read;
    logic full;
    logic empty;
    logic j_end;     // j == count
    logic j_last;    // j + 1 == count
    logic i_last;    // i + 1 == count
    logic id_hit;    // table read data id equals latched id
    logic out_free;  // output register can take a result
  } dp_sts_t;

endpackage

[src/rtsr_dp.sv]
// datapath: record table, sort work memory, scan counters, compare and output register
// depends on rtsr_pkg; driven by rtsr_ctl through dp_cmd_t
module rtsr_dp #(
  parameter int MAX_RECORDS = rtsr_pkg::MAX_RECORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          command,
  input  logic [rtsr_pkg::ID_W-1:0]     item_id,
  input  logic [rtsr_pkg::PRICE_W-1:0]  item_price,
  input  logic [rtsr_pkg::RANK_W-1:0]   item_rank,
  input  logic [rtsr_pkg::KEY_W-1:0]    sort_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rtsr_pkg::STATUS_W-1:0] status,
  output logic [rtsr_pkg::ID_W-1:0]     out_id,
  output logic [rtsr_pkg::PRICE_W-1:0]  out_price,
  output logic [rtsr_pkg::RANK_W-1:0]   out_rank,
  output logic                          last,
  input  rtsr_pkg::dp_cmd_t             cmd,
  output rtsr_pkg::dp_sts_t             sts
);
  import rtsr_pkg::*;

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] MAX_N = CW'(MAX_RECORDS);

  rec_t            store [MAX_RECORDS];
  rec_t            work [MAX_RECORDS];
  logic [AW-1:0]   work_idx [MAX_RECORDS];

  rec_t            st_rdata;
  rec_t            wk_rdata;
  logic [AW-1:0]   wk_ridx;

  logic            cmd_q;
  rec_t            in_rec;
  logic [KEY_W-1:0] key;

  logic [CW-1:0]   count;
  logic [CW-1:0]   i;
  logic [CW-1:0]   j;
  logic [AW-1:0]   m;

  rec_t            head;
  logic [AW-1:0]   head_idx;
  rec_t            minr;
  logic [AW-1:0]   min_idx;

  logic            wk_we;
  logic [AW-1:0]   wk_waddr;
  rec_t            wk_wdata;
  logic [AW-1:0]   wk_widx;
  logic [AW-1:0]   wk_raddr;
  logic            better;

  // latched item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q        <= command;
      in_rec.id    <= item_id;
      in_rec.price <= item_price;
      in_rec.rank  <= item_rank;
      key          <= sort_key;
    end
  end

  // record table: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.st_wr) begin
      store[count[AW-1:0]] <= in_rec;
    end
    if (cmd.st_rd) begin
      st_rdata <= store[j[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.st_wr) begin
      count <= count + CW'(1);
    end
  end

  // work memory write select
  always_comb begin
    wk_we    = cmd.wk_wr_copy | cmd.wk_wr_head | cmd.wk_wr_min;
    wk_waddr = j[AW-1:0];
    wk_wdata = st_rdata;
    wk_widx  = j[AW-1:0];
    if (cmd.wk_wr_head) begin
      wk_waddr = m;
      wk_wdata = head;
      wk_widx  = head_idx;
    end else if (cmd.wk_wr_min) begin
      wk_waddr = i[AW-1:0];
      wk_wdata = minr;
      wk_widx  = min_idx;
    end
  end

  assign wk_raddr = cmd.wk_rd_i ? i[AW-1:0] : j[AW-1:0];

  always_ff @(posedge clk) begin
    if (wk_we) begin
      work[wk_waddr]     <= wk_wdata;
      work_idx[wk_waddr] <= wk_widx;
    end
    if (cmd.wk_rd_i || cmd.wk_rd_j) begin
      wk_rdata <= work[wk_raddr];
      wk_ridx  <= work_idx[wk_raddr];
    end
  end

  // price ties keep first minimum; rank ties resolve on original position
  always_comb begin
    case (key)
      KEY_PRICE: better = wk_rdata.price < minr.price;
      KEY_RANK:  better = (wk_rdata.rank > minr.rank) ||
                          ((wk_rdata.rank == minr.rank) && (wk_ridx < min_idx));
      default:   better = wk_rdata.id < minr.id;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.i_clr) begin
      i <= '0;
    end else if (cmd.i_inc) begin
      i <= i + CW'(1);
    end
    if (cmd.j_clr) begin
      j <= '0;
    end else if (cmd.j_from_i) begin
      j <= i + CW'(1);
    end else if (cmd.j_inc) begin
      j <= j + CW'(1);
    end
    if (cmd.head_ld) begin
      head     <= wk_rdata;
      head_idx <= wk_ridx;
      minr     <= wk_rdata;
      min_idx  <= wk_ridx;
      m        <= i[AW-1:0];
    end else if (cmd.min_upd && better) begin
      minr    <= wk_rdata;
      min_idx <= wk_ridx;
      m       <= j[AW-1:0];
    end
  end

  assign sts.cmd_read = (cmd_q == CMD_READ);
  assign sts.full     = (count == MAX_N);
  assign sts.empty    = (count == '0);
  assign sts.j_end    = (j == count);
  assign sts.j_last   = (j + CW'(1) == count);
  assign sts.i_last   = (i + CW'(1) == count);
  assign sts.id_hit   = (st_rdata.id == in_rec.id);
  assign sts.out_free = !out_valid || !out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status    <= cmd.out_status;
      out_id    <= cmd.out_rec ? minr.id : '0;
      out_price <= cmd.out_rec ? minr.price : '0;
      out_rank  <= cmd.out_rec ? minr.rank : '0;
      last      <= cmd.out_rec ? sts.i_last : 1'b1;
    end
  end

endmodule

[src/rtsr_ctl.sv]
// controller: sequences insert scan, table copy and selection sort passes
// depends on rtsr_pkg; steers rtsr_dp through dp_cmd_t, reads dp_sts_t
module rtsr_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rtsr_pkg::dp_sts_t sts,
  output rtsr_pkg::dp_cmd_t cmd
);
  import rtsr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_DUP_RD,
    S_DUP_CMP,
    S_INS_WR,
    S_RESP,
    S_COPY_RD,
    S_COPY_WR,
    S_HEAD_RD,
    S_HEAD_LD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SWAP_HEAD,
    S_SWAP_MIN,
    S_EMIT
  } state_t;

  state_t  state;
  state_t  state_next;
  status_e resp;
  status_e resp_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    resp_next  = resp;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.j_clr = 1'b1;
        cmd.i_clr = 1'b1;
        if (!sts.cmd_read) begin
          if (sts.full) begin
            resp_next  = ST_FULL;
            state_next = S_RESP;
          end else begin
            state_next = S_DUP_RD;
          end
        end else if (sts.empty) begin
          resp_next  = ST_EMPTY;
          state_next = S_RESP;
        end else begin
          state_next = S_COPY_RD;
        end
      end
      S_DUP_RD: begin
        if (sts.j_end) begin
          state_next = S_INS_WR;
        end else begin
          cmd.st_rd  = 1'b1;
          state_next = S_DUP_CMP;
        end
      end
      S_DUP_CMP: begin
        if (sts.id_hit) begin
          resp_next  = ST_DUP;
          state_next = S_RESP;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = S_DUP_RD;
        end
      end
      S_INS_WR: begin
        cmd.st_wr  = 1'b1;
        resp_next  = ST_ADDED;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp;
          state_next     = S_IDLE;
        end
      end
      S_COPY_RD: begin
        cmd.st_rd  = 1'b1;
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.wk_wr_copy = 1'b1;
        cmd.j_inc      = 1'b1;
        state_next     = sts.j_last ? S_HEAD_RD : S_COPY_RD;
      end
      S_HEAD_RD: begin
        cmd.wk_rd_i = 1'b1;
        state_next  = S_HEAD_LD;
      end
      S_HEAD_LD: begin
        cmd.head_ld  = 1'b1;
        cmd.j_from_i = 1'b1;
        state_next   = sts.i_last ? S_EMIT : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.wk_rd_j = 1'b1;
        state_next  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.min_upd = 1'b1;
        cmd.j_inc   = 1'b1;
        state_next  = sts.j_last ? S_SWAP_HEAD : S_SCAN_RD;
      end
      S_SWAP_HEAD: begin
        cmd.wk_wr_head = 1'b1;
        state_next     = S_SWAP_MIN;
      end
      S_SWAP_MIN: begin
        cmd.wk_wr_min = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_rec    = 1'b1;
          cmd.out_status = ST_RECORD;
          if (sts.i_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.i_inc  = 1'b1;
            state_next = S_HEAD_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      resp  <= ST_ADDED;
    end else begin
      state <= state_next;
      resp  <= resp_next;
    end
  end

endmodule

[src/record_table_sorted_readout_top.sv]
// record table with sorted readout: top level, controller plus datapath
// insert: checks for a full table, then scans the stored records for a duplicate id and appends
// read: copies the table to the work memory, then each pass loads a head, scans the rest and swaps
// passes are a selection sort on a work copy; output stalls hold up both commands
// one item at a time; the next item is taken once the last result sits in the output register
// rst (synchronous, active high) empties the table and drops any pending result
module record_table_sorted_readout_top #(
  parameter int MAX_RECORDS = rtsr_pkg::MAX_RECORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [rtsr_pkg::ID_W-1:0]     item_id,
  input  logic [rtsr_pkg::PRICE_W-1:0]  item_price,
  input  logic [rtsr_pkg::RANK_W-1:0]   item_rank,
  input  logic [rtsr_pkg::KEY_W-1:0]    sort_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rtsr_pkg::STATUS_W-1:0] status,
  output logic [rtsr_pkg::ID_W-1:0]     out_id,
  output logic [rtsr_pkg::PRICE_W-1:0]  out_price,
  output logic [rtsr_pkg::RANK_W-1:0]   out_rank,
  output logic                          last
);
  import rtsr_pkg::*;

  // command and status bundles between controller and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller: walks insert, copy, scan and swap steps
  rtsr_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: table, work copy, counters, compare and output register
  rtsr_dp #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .command    (command),
    .item_id    (item_id),
    .item_price (item_price),
    .item_rank  (item_rank),
    .sort_key   (sort_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_id     (out_id),
    .out_price  (out_price),
    .out_rank   (out_rank),
    .last       (last),
    .cmd        (cmd),
    .sts        (sts)
  );

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after an accepted item");

  // the work memory has a single write port
  a_one_work_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wk_wr_copy, cmd.wk_wr_head, cmd.wk_wr_min}))
    else $error("two work memory writes in one cycle");

  // no append into a full table
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    sts.full |-> !cmd.st_wr)
    else $error("append into full table");

  // status-only results always close their item
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_RECORD)) |-> last)
    else $error("status result without last");

  // the output register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

endmodule

[dv/readout_checker.sv]
`timescale 1ns / 1ps
// readout_checker: watches both item channels of the record table and checks every result
// keeps its own copy of the table and predicts statuses and sorted readouts; needs rtsr_pkg
module readout_checker #(
  parameter int DEPTH = rtsr_pkg::MAX_RECORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          command,
  input  logic [rtsr_pkg::ID_W-1:0]     item_id,
  input  logic [rtsr_pkg::PRICE_W-1:0]  item_price,
  input  logic [rtsr_pkg::RANK_W-1:0]   item_rank,
  input  logic [rtsr_pkg::KEY_W-1:0]    sort_key,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [rtsr_pkg::STATUS_W-1:0] status,
  input  logic [rtsr_pkg::ID_W-1:0]     out_id,
  input  logic [rtsr_pkg::PRICE_W-1:0]  out_price,
  input  logic [rtsr_pkg::RANK_W-1:0]   out_rank,
  input  logic                          last,
  output int                            mismatches,
  output int                            waiting,
  output int                            checked,
  output int                            stored
);
  import rtsr_pkg::*;

  typedef struct packed {
    status_e status;
    rec_t    rec;
    logic    last;
  } answer_t;

  answer_t awaited[$];
  rec_t    rec_mem [DEPTH];
  rec_t    work_buf [DEPTH];
  int      fill = 0;
  int      bad = 0;
  int      good_count = 0;

  function automatic void push_answer(status_e st, rec_t r, logic fin);
    answer_t a;
    a.status = st;
    a.rec = r;
    a.last = fin;
    awaited.push_back(a);
  endfunction

  // orders work_buf[0..n-1] for one readout
  function automatic void order_records(logic [KEY_W-1:0] key, int n);
    rec_t hold;
    int   m;
    int   j;
    if (key == KEY_PRICE) begin
      // first minimum swapped into place: this fixes the order of equal prices
      for (int i = 0; i + 1 < n; i++) begin
        m = i;
        for (j = i + 1; j < n; j++)
          if (work_buf[j].price < work_buf[m].price) m = j;
        hold = work_buf[m];
        work_buf[m] = work_buf[i];
        work_buf[i] = hold;
      end
    end else begin
      // insertion: rank descending keeps insertion order on ties, else id ascending
      for (int i = 1; i < n; i++) begin
        hold = work_buf[i];
        j = i;
        while (j > 0 && ((key == KEY_RANK) ? (work_buf[j-1].rank < hold.rank)
                                           : (work_buf[j-1].id > hold.id))) begin
          work_buf[j] = work_buf[j-1];
          j--;
        end
        work_buf[j] = hold;
      end
    end
  endfunction

  function automatic void predict_table_answer(logic cmd, logic [ID_W-1:0] id,
                                               logic [PRICE_W-1:0] price,
                                               logic [RANK_W-1:0] rank,
                                               logic [KEY_W-1:0] key);
    rec_t blank;
    rec_t r;
    logic hit;
    blank = '0;
    hit = 1'b0;
    if (cmd == CMD_INSERT) begin
      if (fill >= DEPTH) begin
        push_answer(ST_FULL, blank, 1'b1);
      end else begin
        for (int i = 0; i < fill; i++)
          if (rec_mem[i].id == id) hit = 1'b1;
        if (hit) begin
          push_answer(ST_DUP, blank, 1'b1);
        end else begin
          r.id = id;
          r.price = price;
          r.rank = rank;
          rec_mem[fill] = r;
          fill++;
          push_answer(ST_ADDED, blank, 1'b1);
        end
      end
    end else if (fill == 0) begin
      push_answer(ST_EMPTY, blank, 1'b1);
    end else begin
      for (int i = 0; i < fill; i++) work_buf[i] = rec_mem[i];
      order_records(key, fill);
      for (int i = 0; i < fill; i++) push_answer(ST_RECORD, work_buf[i], i + 1 == fill);
    end
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      bad++;
      if (bad <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      fill = 0;
      awaited.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          bad++;
          if (bad <= 40)
            $display("%0t: result with none expected, status %0h id %0h", $time, status,
                     out_id);
        end else begin
          want = awaited.pop_front();
          good_count++;
          check_field("status", 32'(want.status), 32'(status));
          check_field("out_id", 32'(want.rec.id), 32'(out_id));
          check_field("out_price", 32'(want.rec.price), 32'(out_price));
          check_field("out_rank", 32'(want.rec.rank), 32'(out_rank));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      if (in_valid && !in_stall)
        predict_table_answer(command, item_id, item_price, item_rank, sort_key);
    end
    mismatches <= bad;
    waiting    <= awaited.size();
    checked    <= good_count;
    stored     <= fill;
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// testbench: clock, reset, stimulus and verdict for record_table_sorted_readout_top
// depends on rtsr_pkg, the block itself and readout_checker
module testbench;
  import rtsr_pkg::*;

  localparam int RANDOM_ITEMS = 260;
  localparam int TAIL_ITEMS   = 40;     // final items run with no idling at all
  // long enough for a full 32-record read with margin, plus the longest receiver stall
  localparam int QUIET_LIMIT  = 10000;
  localparam int SETTLE       = 100;    // cycles watched after the last result

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                command = CMD_INSERT;
  logic [ID_W-1:0]     item_id = '0;
  logic [PRICE_W-1:0]  item_price = '0;
  logic [RANK_W-1:0]   item_rank = '0;
  logic [KEY_W-1:0]    sort_key = KEY_ID;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_id;
  logic [PRICE_W-1:0]  out_price;
  logic [RANK_W-1:0]   out_rank;
  logic                last;

  int   mismatches;
  int   waiting;
  int   checked;
  int   stored;
  int   sent = 0;
  int   reads = 0;
  int   quiet_cycles = 0;
  int   stall_left = 0;
  int   calm_left = 0;
  logic tail_mode = 1'b0;
  logic [ID_W-1:0] used_ids[$];

  always #5 clk = ~clk;

  record_table_sorted_readout_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .item_id    (item_id),
    .item_price (item_price),
    .item_rank  (item_rank),
    .sort_key   (sort_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_id     (out_id),
    .out_price  (out_price),
    .out_rank   (out_rank),
    .last       (last)
  );

  readout_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .item_id    (item_id),
    .item_price (item_price),
    .item_rank  (item_rank),
    .sort_key   (sort_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_id     (out_id),
    .out_price  (out_price),
    .out_rank   (out_rank),
    .last       (last),
    .mismatches (mismatches),
    .waiting    (waiting),
    .checked    (checked),
    .stored     (stored)
  );

  // watchdog: any cycle where neither channel moves an item counts toward the limit
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall bursts, with now and then a long calm stretch
  always @(posedge clk) begin
    if (rst || tail_mode) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      if ($urandom_range(0, 9) == 0) calm_left <= $urandom_range(40, 400);
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 12);
    end
  end

  // present one item and hold it until the block takes it; valid stays high on return
  task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                           input logic [PRICE_W-1:0] price, input logic [RANK_W-1:0] rank,
                           input logic [KEY_W-1:0] key);
    in_valid   <= 1'b1;
    command    <= cmd;
    item_id    <= id;
    item_price <= price;
    item_rank  <= rank;
    sort_key   <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (cmd == CMD_READ) reads++;
  endtask

  task automatic rest_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off the sender until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  initial begin
    logic               cmd;
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [RANK_W-1:0]  rank;
    logic [KEY_W-1:0]   key;
    int                 calm_items;

    calm_items = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reads of an empty table, with noise in the unused fields
    send_item(CMD_READ, 16'hFFFF, 20'hFFFFF, 8'hFF, KEY_ID);
    send_item(CMD_READ, 16'h0000, 20'h00000, 8'h00, 2'd3);
    send_item(CMD_READ, 16'h5A5A, 20'hA5A5A, 8'h5A, KEY_RANK);
    // field extremes, price and rank ties, a duplicate id
    send_item(CMD_INSERT, 16'h0000, 20'h00000, 8'h00, KEY_ID);
    send_item(CMD_INSERT, 16'hFFFF, 20'hFFFFF, 8'hFF, 2'd3);
    send_item(CMD_INSERT, 16'h0000, 20'd1000000, 8'h07, KEY_PRICE);
    send_item(CMD_INSERT, 16'h8000, 20'h00000, 8'hFF, KEY_ID);
    send_item(CMD_INSERT, 16'h00FF, 20'hFFFFF, 8'h00, KEY_ID);
    send_item(CMD_INSERT, 16'h1234, 20'd1000000, 8'h80, KEY_ID);
    send_item(CMD_INSERT, 16'h5555, 20'h00000, 8'h80, KEY_ID);
    send_item(CMD_INSERT, 16'hAAAA, 20'd500, 8'h01, KEY_ID);
    // every sort order, the unassigned key included
    send_item(CMD_READ, 16'h0000, 20'h00000, 8'h00, KEY_ID);
    send_item(CMD_READ, 16'hFFFF, 20'hFFFFF, 8'hFF, KEY_PRICE);
    send_item(CMD_READ, 16'h0000, 20'h00000, 8'h00, KEY_RANK);
    send_item(CMD_READ, 16'h0000, 20'h00000, 8'h00, 2'd3);
    send_item(CMD_INSERT, 16'hFFFF, 20'd42, 8'h42, KEY_ID);
    used_ids = '{16'h0000, 16'hFFFF, 16'h8000, 16'h00FF, 16'h1234, 16'h5555, 16'hAAAA};
    drain_results();

    // random part: mostly inserts, so the table fills and then refuses as full;
    // prices and ranks often come from small sets to force ties
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      cmd = ($urandom_range(0, 99) < 25) ? CMD_READ : CMD_INSERT;
      if ($urandom_range(0, 4) == 0)
        id = used_ids[$urandom_range(0, used_ids.size() - 1)];
      else
        id = ID_W'($urandom);
      case ($urandom_range(0, 5))
        0, 1:    price = PRICE_W'($urandom_range(0, 7) * 125);
        2:       price = PRICE_W'($urandom);
        default: price = PRICE_W'($urandom_range(0, 1000000));
      endcase
      if ($urandom_range(0, 2) == 0) rank = RANK_W'($urandom_range(0, 3) * 85);
      else rank = RANK_W'($urandom);
      key = KEY_W'($urandom);
      if (cmd == CMD_INSERT) used_ids.push_back(id);
      if (k == RANDOM_ITEMS - TAIL_ITEMS) tail_mode <= 1'b1;
      send_item(cmd, id, price, rank, key);

      // one more full drain midway, with the table well populated
      if (k == RANDOM_ITEMS / 2) begin
        drain_results();
      end else if (k < RANDOM_ITEMS - TAIL_ITEMS) begin
        if (calm_items > 0) begin
          calm_items--;
        end else if ($urandom_range(0, 30) == 0) begin
          calm_items = $urandom_range(5, 20);
        end else if ($urandom_range(0, 3) == 0) begin
          rest_sender($urandom_range(1, 12));
        end
      end
    end

    // wait out the remaining results, then watch for strays
    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("summary: %0d items sent, %0d of them reads; %0d results checked", sent, reads,
             checked);
    $display("summary: table ended with %0d records", stored);
    if (mismatches == 0 && waiting == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[record_table_sorted_readout_top.f]
src/rtsr_pkg.sv
src/rtsr_dp.sv
src/rtsr_ctl.sv
src/record_table_sorted_readout_top.sv
dv/readout_checker.sv
dv/testbench.sv
